/* sv/oid_handler_lookup_macros.svh */
// assertion macros for the handler lookup block
`ifndef OID_HANDLER_LOOKUP_MACROS_SVH
`define OID_HANDLER_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
`define OHL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OHL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OHL_ASSERT(lbl, prop, msg)
`define OHL_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* sv/ohl_pkg.sv */
// ----------------------------------------------------------------------------
// ohl_pkg
// shared constants and types of the handler lookup block
// ----------------------------------------------------------------------------
`default_nettype none
package ohl_pkg;
  localparam int TableEntries = 16;
  localparam int MaxIdBytes   = 32;
  localparam int EntryW = $clog2(TableEntries);
  localparam int PosW   = $clog2(MaxIdBytes);
  localparam int LenW   = $clog2(MaxIdBytes + 1);
  localparam int CntW   = $clog2(TableEntries + 1);

  typedef enum logic [1:0] {
    CMD_WR_HANDLER = 2'd0,
    CMD_SET_LEN    = 2'd1,
    CMD_WR_REQUEST = 2'd2,
    CMD_LOOKUP     = 2'd3
  } cmd_e;

  // token that travels down the compare chain
  typedef struct packed {
    logic              valid;
    logic [EntryW-1:0] idx;
    logic [LenW-1:0]   hl;
    logic              eq;
  } token_t;

  // write controls broadcast to every cell
  typedef struct packed {
    logic              hdl_we;
    logic              req_we;
    logic [EntryW-1:0] entry;
    logic [PosW-1:0]   pos;
    logic [7:0]        data;
  } cell_wr_t;
endpackage
`default_nettype wire

/* sv/ohl_cell.sv */
// ----------------------------------------------------------------------------
// ohl_cell
// one byte column of the table; compares a passing token against the request
// ----------------------------------------------------------------------------
`default_nettype none
module ohl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ohl_pkg::PosW-1:0]  pos_i,
  input  logic [ohl_pkg::LenW-1:0]  req_len_i,
  input  ohl_pkg::cell_wr_t         wr_i,
  input  ohl_pkg::token_t           tok_i,
  output ohl_pkg::token_t           tok_o
);
  import ohl_pkg::*;

  logic [7:0]        col_q [TableEntries];
  logic [7:0]        req_q;
  logic              valid_q;
  logic [EntryW-1:0] idx_q;
  logic [LenW-1:0]   hl_q;
  logic              eq_q;
  logic              eq_d;

  // byte writes addressed to this column
  always_ff @(posedge clk_i) begin
    if (wr_i.hdl_we && wr_i.pos == pos_i) col_q[wr_i.entry] <= wr_i.data;
    if (wr_i.req_we && wr_i.pos == pos_i) req_q <= wr_i.data;
  end

  // bytes past the request length do not take part
  always_comb begin
    eq_d = tok_i.eq & (({1'b0, pos_i} >= req_len_i) || (col_q[tok_i.idx] == req_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= tok_i.valid;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= tok_i.idx;
    hl_q  <= tok_i.hl;
    eq_q  <= eq_d;
  end

  always_comb begin
    tok_o.valid = valid_q;
    tok_o.idx   = idx_q;
    tok_o.hl    = hl_q;
    tok_o.eq    = eq_q;
  end
endmodule
`default_nettype wire

/* sv/oid_handler_lookup.sv */
// ----------------------------------------------------------------------------
// oid_handler_lookup
// sorted handler table with exact and walk lookup of encoded identifiers
// ----------------------------------------------------------------------------
// Usage: a command transfer is taken when start is high and busy is low.
// Commands 0..2 write a handler byte, a handler length or a request byte and
// give no result. Command 3 runs a lookup: busy rises, entries
// start_index..limit-1 enter a chain of 32 byte cells one per cycle, each
// cell checks its byte column, and the tail resolves the walk rules in entry
// order. After the last token leaves the chain, valid_o pulses for one cycle
// with found_o and match_index_o, and busy drops in the following cycle.
// Busy stays high until the result strobe, which falls in the last busy
// cycle; a lookup with no entries in range goes straight to the strobe. The run is
// set by the injection of one entry per cycle plus the 32-cell chain depth.
// The receiver cannot stall: valid_o is a one-cycle strobe.
// The user must write entry_count through cfg_we_i/cfg_wdata_i only while
// idle; the block does not enforce this. Reset clears control state and
// entry_count; table and request bytes stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "oid_handler_lookup_macros.svh"
module oid_handler_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  command_i,
  input  logic [ohl_pkg::EntryW-1:0]  entry_index_i,
  input  logic [ohl_pkg::PosW-1:0]    byte_index_i,
  input  logic [7:0]                  byte_value_i,
  input  logic [ohl_pkg::LenW-1:0]    length_i,
  input  logic                        walk_i,
  input  logic [ohl_pkg::CntW-1:0]    start_index_i,
  input  logic                        cfg_we_i,
  input  logic [ohl_pkg::CntW-1:0]    cfg_wdata_i,
  output logic                        valid_o,
  output logic                        found_o,
  output logic [ohl_pkg::EntryW-1:0]  match_index_o
);
  import ohl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   inj_q, limit_q, rem_q;
  logic [LenW-1:0]   len_q;
  logic              walk_q, take_q, hit_q;
  logic [EntryW-1:0] where_q;
  logic [LenW-1:0]   hl_q [TableEntries];
  logic              accept;
  cmd_e              cmd;
  logic [LenW-1:0]   len_clamp;
  logic [CntW-1:0]   limit_d;
  cell_wr_t          wr;
  token_t            chain [MaxIdBytes+1];
  token_t            tail;

  assign accept    = start && !busy;
  assign cmd       = cmd_e'(command_i);
  assign len_clamp = (length_i > LenW'(MaxIdBytes)) ? LenW'(MaxIdBytes) : length_i;
  assign limit_d   = (count_q > CntW'(TableEntries)) ? CntW'(TableEntries) : count_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       count_q <= '0;
    else if (cfg_we_i) count_q <= cfg_wdata_i;
  end

  // handler lengths
  always_ff @(posedge clk_i) begin
    if (accept && cmd == CMD_SET_LEN) hl_q[entry_index_i] <= len_clamp;
  end

  always_comb begin
    wr.hdl_we = accept && cmd == CMD_WR_HANDLER;
    wr.req_we = accept && cmd == CMD_WR_REQUEST;
    wr.entry  = entry_index_i;
    wr.pos    = byte_index_i;
    wr.data   = byte_value_i;
  end

  // token injection at the head of the chain
  assign chain[0] = {state_q == S_RUN && inj_q < limit_q, inj_q[EntryW-1:0],
                     hl_q[inj_q[EntryW-1:0]], 1'b1};

  // compare chain, one cell per byte position
  for (genvar k = 0; k < MaxIdBytes; k++) begin : g_cell
    ohl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .pos_i     (PosW'(k)),
      .req_len_i (len_q),
      .wr_i      (wr),
      .tok_i     (chain[k]),
      .tok_o     (chain[k+1])
    );
  end

  assign tail = chain[MaxIdBytes];

  // sequencer and walk resolution at the chain tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inj_q   <= '0;
      limit_q <= '0;
      rem_q   <= '0;
      len_q   <= '0;
      walk_q  <= 1'b0;
      take_q  <= 1'b0;
      hit_q   <= 1'b0;
      where_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && cmd == CMD_LOOKUP) begin
            inj_q   <= start_index_i;
            limit_q <= limit_d;
            len_q   <= len_clamp;
            walk_q  <= walk_i;
            take_q  <= 1'b0;
            hit_q   <= 1'b0;
            where_q <= '0;
            if (start_index_i < limit_d) begin
              rem_q   <= limit_d - start_index_i;
              state_q <= S_RUN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_RUN: begin
          if (chain[0].valid) inj_q <= inj_q + 1'b1;
          if (tail.valid) begin
            rem_q <= rem_q - 1'b1;
            if (rem_q == CntW'(1)) state_q <= S_DONE;
            if (!hit_q) begin
              if (take_q) begin
                hit_q <= 1'b1; where_q <= tail.idx;
              end else if (tail.hl == len_q && tail.eq) begin
                if (walk_q) take_q <= 1'b1;
                else begin hit_q <= 1'b1; where_q <= tail.idx; end
              end else if (walk_q && tail.hl > len_q && tail.eq) begin
                hit_q <= 1'b1; where_q <= tail.idx;
              end
            end
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = state_q != S_IDLE;
  assign valid_o       = state_q == S_DONE;
  assign found_o       = hit_q;
  assign match_index_o = hit_q ? where_q : '0;

  `OHL_ASSERT(a_strobe_single, valid_o |=> !valid_o, "result strobe longer than one cycle")
  `OHL_ASSERT(a_drained_idle, !busy |-> !tail.valid, "chain token outside a lookup")
  `OHL_ASSERT(a_done_drained, valid_o |-> (rem_q == '0 || !hit_q && !take_q), "result early")
  `OHL_ASSERT_RST(a_reset_idle, !rst_ni |-> !busy, "busy during reset")
endmodule
`default_nettype wire
